// ----- hw/rtl/cbq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Cascaded biquad package
// Sizes, control codes, the microcode program and coefficient helpers shared
// by the filter and its checker.
// ----------------------------------------------------------------------------
package cbq_pkg;

	localparam int NUM_SECTIONS    = 4;
	localparam int SAMPLE_WIDTH    = 16;
	localparam int COEF_WIDTH      = 16;
	localparam int SECTION_WIDTH   = SAMPLE_WIDTH + 8;
	localparam int COEF_FRAC       = COEF_WIDTH - 2;
	localparam int NUM_REGS        = 5;
	localparam int REG_WIDTH       = 64;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int PROD_WIDTH      = COEF_WIDTH + SECTION_WIDTH;
	localparam int ACC_WIDTH       = PROD_WIDTH + 3;
	localparam int SHIFT_WIDTH     = ACC_WIDTH - COEF_FRAC;
	localparam int SEC_WIDTH       = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
	localparam int STEP_WIDTH      = 3;
	localparam int TDATA_WIDTH     = ((SAMPLE_WIDTH + 7) / 8) * 8;

	// Coefficient register indexes.
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2
	} coef_reg_t;

	// Multiplier operand selection.
	typedef enum logic [2:0] {
		OPD_CUR,
		OPD_X1,
		OPD_X2,
		OPD_Y1,
		OPD_Y2
	} opd_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_LOOP,
		SEQ_DONE
	} seq_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		opd_sel_t  opd;
		coef_reg_t coef;
		logic      mul_en;
		acc_op_t   acc_op;
		logic      wb;
		seq_op_t   seq;
	} ucode_t;

	// Microcode addresses.
	localparam logic [STEP_WIDTH-1:0] UC_MAC_B0 = 3'd0;
	localparam logic [STEP_WIDTH-1:0] UC_MAC_B1 = 3'd1;
	localparam logic [STEP_WIDTH-1:0] UC_MAC_B2 = 3'd2;
	localparam logic [STEP_WIDTH-1:0] UC_MAC_A1 = 3'd3;
	localparam logic [STEP_WIDTH-1:0] UC_MAC_A2 = 3'd4;
	localparam logic [STEP_WIDTH-1:0] UC_DRAIN  = 3'd5;
	localparam logic [STEP_WIDTH-1:0] UC_WRBACK = 3'd6;
	localparam logic [STEP_WIDTH-1:0] UC_OUT    = 3'd7;

	// The program: each of the five multiply steps issues one product; the accumulator
	// trails them, taking each product from the multiplier register.
	function automatic ucode_t ucode_rom(input logic [STEP_WIDTH-1:0] step);
		ucode_t uc;
		uc = '{opd: OPD_CUR, coef: REG_B0, mul_en: 1'b0, acc_op: ACC_HOLD,
		       wb: 1'b0, seq: SEQ_NEXT};
		unique case (step)
			UC_MAC_B0: begin
				uc.opd = OPD_CUR; uc.coef = REG_B0; uc.mul_en = 1'b1;
			end
			UC_MAC_B1: begin
				uc.opd = OPD_X1; uc.coef = REG_B1; uc.mul_en = 1'b1; uc.acc_op = ACC_LOAD;
			end
			UC_MAC_B2: begin
				uc.opd = OPD_X2; uc.coef = REG_B2; uc.mul_en = 1'b1; uc.acc_op = ACC_ADD;
			end
			UC_MAC_A1: begin
				uc.opd = OPD_Y1; uc.coef = REG_A1; uc.mul_en = 1'b1; uc.acc_op = ACC_ADD;
			end
			UC_MAC_A2: begin
				uc.opd = OPD_Y2; uc.coef = REG_A2; uc.mul_en = 1'b1; uc.acc_op = ACC_SUB;
			end
			UC_DRAIN: begin
				uc.acc_op = ACC_SUB;
			end
			UC_WRBACK: begin
				uc.wb = 1'b1; uc.seq = SEQ_LOOP;
			end
			UC_OUT: begin
				uc.seq = SEQ_DONE;
			end
			default: begin
				uc.seq = SEQ_DONE;
			end
		endcase
		return uc;
	endfunction

	// Coefficient of one section; a field that runs past the register is zero.
	function automatic logic signed [COEF_WIDTH-1:0] coef_field(
		input logic [REG_WIDTH-1:0] pack,
		input logic [SEC_WIDTH-1:0] sec
	);
		logic signed [COEF_WIDTH-1:0] c;
		c = '0;
		for (int s = 0; s < NUM_SECTIONS; s++) begin
			if ((int'(sec) == s) && ((s + 1) * COEF_WIDTH <= REG_WIDTH))
				c = pack[s*COEF_WIDTH +: COEF_WIDTH];
		end
		return c;
	endfunction

	// Unity gain (1.0 in Q2.14) in every section's b0 field.
	function automatic logic [REG_WIDTH-1:0] b0_reset_value();
		logic [REG_WIDTH-1:0] v;
		v = '0;
		for (int s = 0; s < NUM_SECTIONS; s++) begin
			if ((s + 1) * COEF_WIDTH <= REG_WIDTH)
				v[s*COEF_WIDTH +: COEF_WIDTH] = COEF_WIDTH'(1) << COEF_FRAC;
		end
		return v;
	endfunction

	localparam logic [REG_WIDTH-1:0] B0_RESET = b0_reset_value();

endpackage
`default_nettype wire

// ----- hw/rtl/cascaded_biquad_iir_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Cascaded biquad IIR filter
// Four direct-form-I biquad sections in series, run by a microcoded sequencer
// around one shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// Each input transaction carries one Q1.15 sample and a clear flag. The sample
// runs through four direct-form-I sections, y = b0*x + b1*x1 + b2*x2 - a1*y1
// - a2*y2, with Q2.14 coefficients from five 64-bit registers (section 0 in
// the low 16 bits). A single 16x24 multiplier is shared by all twenty products:
// a sample takes seven steps per section (five products, one accumulator drain
// and one write-back) plus one output step, and the block goes back to idle
// before it takes the next sample. The result sits in an output register, so
// the next sample is accepted while a result still waits.
// Section values are rounded and saturated to 24 bits, the final sample to 16
// bits; the tuser flag of a result reports any clipping along the way.
// Coefficient writes are accepted at every cycle and belong between samples.
module cascaded_biquad_iir_filter (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write channel.
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [cbq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [cbq_pkg::REG_WIDTH-1:0]    cfg_data,
	// Sample input stream.
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [cbq_pkg::TDATA_WIDTH-1:0]  s_tdata,  // [15:0] sample_in
	input  wire logic                             s_tuser,  // [0] clear_history
	// Filtered output stream.
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	output      logic [cbq_pkg::TDATA_WIDTH-1:0]  m_tdata,  // [15:0] sample_out
	output      logic                             m_tuser   // [0] saturated
);
	import cbq_pkg::*;

	localparam logic [SEC_WIDTH-1:0] SEC_LAST = SEC_WIDTH'(NUM_SECTIONS - 1);
	localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) << (COEF_FRAC - 1);
	localparam logic signed [SECTION_WIDTH-1:0] SEC_MAX = {1'b0, {(SECTION_WIDTH-1){1'b1}}};
	localparam logic signed [SECTION_WIDTH-1:0] SEC_MIN = {1'b1, {(SECTION_WIDTH-1){1'b0}}};
	localparam logic signed [SAMPLE_WIDTH-1:0]  OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0]  OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam int EXT = SECTION_WIDTH - SAMPLE_WIDTH;

	// Control state.
	state_t                  state_q, state_d;
	logic [STEP_WIDTH-1:0]   step_q;
	logic [SEC_WIDTH-1:0]    sec_q;
	logic                    running;
	logic                    in_accept;
	logic                    out_free;
	logic                    out_load;
	ucode_t                  uc;

	// Coefficient registers.
	logic [REG_WIDTH-1:0]    coef_q [NUM_REGS];

	// Histories and working registers.
	logic signed [SAMPLE_WIDTH-1:0]  inh0_q, inh1_q;
	logic signed [SECTION_WIDTH-1:0] cur_q, x1_q, x2_q;
	logic signed [SECTION_WIDTH-1:0] y1_q [NUM_SECTIONS];
	logic signed [SECTION_WIDTH-1:0] y2_q [NUM_SECTIONS];
	logic signed [PROD_WIDTH-1:0]    prod_s1;
	logic signed [ACC_WIDTH-1:0]     acc_q;
	logic                            sat_q;

	// Output register.
	logic                            out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0]  out_data_q;
	logic                            out_sat_q;

	// Datapath nets.
	logic signed [SECTION_WIDTH-1:0] opd;
	logic signed [COEF_WIDTH-1:0]    coef;
	logic signed [ACC_WIDTH-1:0]     prod_ext;
	logic signed [SHIFT_WIDTH-1:0]   acc_shift;
	logic                            sec_ovf;
	logic signed [SECTION_WIDTH-1:0] sec_y;
	logic                            out_ovf;
	logic signed [SAMPLE_WIDTH-1:0]  out_y;
	logic signed [SECTION_WIDTH-1:0] sample_ext;

	assign cfg_ready = 1'b1;
	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign uc        = ucode_rom(step_q);
	assign out_load  = running && (step_q == UC_OUT) && out_free;

	// Sequencer state: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_accept) state_d = ST_RUN;
			ST_RUN:  if ((step_q == UC_OUT) && out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer state: outputs.
	always_comb begin
		s_tready = 1'b0;
		running  = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_RUN:  running  = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Step counter and section counter with the loop over sections.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= UC_MAC_B0;
			sec_q  <= '0;
		end else if (in_accept) begin
			step_q <= UC_MAC_B0;
			sec_q  <= '0;
		end else if (running) begin
			case (uc.seq)
				SEQ_NEXT: step_q <= step_q + STEP_WIDTH'(1);
				SEQ_LOOP: begin
					if (sec_q == SEC_LAST) begin
						step_q <= UC_OUT;
					end else begin
						step_q <= UC_MAC_B0;
						sec_q  <= sec_q + SEC_WIDTH'(1);
					end
				end
				default: step_q <= step_q;
			endcase
		end
	end

	// Coefficient registers; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++)
				coef_q[r] <= (r == int'(REG_B0)) ? B0_RESET : '0;
		end else if (cfg_valid && (cfg_index < CFG_INDEX_WIDTH'(NUM_REGS))) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// Operand and coefficient selection for the shared multiplier.
	always_comb begin
		case (uc.opd)
			OPD_CUR: opd = cur_q;
			OPD_X1:  opd = x1_q;
			OPD_X2:  opd = x2_q;
			OPD_Y1:  opd = y1_q[sec_q];
			OPD_Y2:  opd = y2_q[sec_q];
			default: opd = cur_q;
		endcase
	end

	always_comb begin
		case (uc.coef)
			REG_B0:  coef = coef_field(coef_q[REG_B0], sec_q);
			REG_B1:  coef = coef_field(coef_q[REG_B1], sec_q);
			REG_B2:  coef = coef_field(coef_q[REG_B2], sec_q);
			REG_A1:  coef = coef_field(coef_q[REG_A1], sec_q);
			REG_A2:  coef = coef_field(coef_q[REG_A2], sec_q);
			default: coef = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (running && uc.mul_en)
			prod_s1 <= coef * opd;
	end

	assign prod_ext = {{(ACC_WIDTH-PROD_WIDTH){prod_s1[PROD_WIDTH-1]}}, prod_s1};

	// Accumulator. The rounding half is folded in with the first product.
	always_ff @(posedge clk) begin
		if (running) begin
			case (uc.acc_op)
				ACC_LOAD: acc_q <= ROUND_HALF + prod_ext;
				ACC_ADD:  acc_q <= acc_q + prod_ext;
				ACC_SUB:  acc_q <= acc_q - prod_ext;
				default:  acc_q <= acc_q;
			endcase
		end
	end

	// Floor shift back to Q9.15 and saturate to the section width.
	assign acc_shift = acc_q[ACC_WIDTH-1:COEF_FRAC];
	assign sec_ovf   = !((&acc_shift[SHIFT_WIDTH-1:SECTION_WIDTH-1]) ||
	                     !(|acc_shift[SHIFT_WIDTH-1:SECTION_WIDTH-1]));
	assign sec_y     = !sec_ovf ? acc_shift[SECTION_WIDTH-1:0] :
	                   (acc_shift[SHIFT_WIDTH-1] ? SEC_MIN : SEC_MAX);

	// Final saturation of the last section's output to the sample width.
	assign out_ovf = !((&cur_q[SECTION_WIDTH-1:SAMPLE_WIDTH-1]) ||
	                   !(|cur_q[SECTION_WIDTH-1:SAMPLE_WIDTH-1]));
	assign out_y   = !out_ovf ? cur_q[SAMPLE_WIDTH-1:0] :
	                 (cur_q[SECTION_WIDTH-1] ? OUT_MIN : OUT_MAX);

	assign sample_ext = {{EXT{s_tdata[SAMPLE_WIDTH-1]}}, s_tdata[SAMPLE_WIDTH-1:0]};

	// Input history and section histories. At write-back the old outputs of a
	// section become the delayed inputs of the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inh0_q <= '0;
			inh1_q <= '0;
			for (int s = 0; s < NUM_SECTIONS; s++) begin
				y1_q[s] <= '0;
				y2_q[s] <= '0;
			end
		end else if (in_accept) begin
			inh0_q <= s_tdata[SAMPLE_WIDTH-1:0];
			inh1_q <= s_tuser ? '0 : inh0_q;
			if (s_tuser) begin
				for (int s = 0; s < NUM_SECTIONS; s++) begin
					y1_q[s] <= '0;
					y2_q[s] <= '0;
				end
			end
		end else if (running && uc.wb) begin
			y1_q[sec_q] <= sec_y;
			y2_q[sec_q] <= y1_q[sec_q];
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cur_q <= sample_ext;
			x1_q  <= s_tuser ? '0 : {{EXT{inh0_q[SAMPLE_WIDTH-1]}}, inh0_q};
			x2_q  <= s_tuser ? '0 : {{EXT{inh1_q[SAMPLE_WIDTH-1]}}, inh1_q};
		end else if (running && uc.wb) begin
			cur_q <= sec_y;
			x1_q  <= y1_q[sec_q];
			x2_q  <= y2_q[sec_q];
		end
	end

	// Clip flag collected over the whole sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (in_accept) begin
			sat_q <= 1'b0;
		end else if (running && uc.wb && sec_ovf) begin
			sat_q <= 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_y;
			out_sat_q  <= sat_q || out_ovf;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_WIDTH'($unsigned(out_data_q));
	assign m_tuser  = out_sat_q;

endmodule
`default_nettype wire

// ----- hw/rtl/cbq_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Cascaded biquad port checker
// Concurrent checks on the filter's stream ports, bound into the filter module.
// ----------------------------------------------------------------------------
module cbq_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [cbq_pkg::TDATA_WIDTH-1:0] m_tdata,
	input wire logic                            m_tuser
);
	import cbq_pkg::*;

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// One sample at a time: the block is busy right after taking a sample.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again before the sample finished");

	// Finishing a sample always leaves its result in the output register.
	a_result_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("sample finished without a result");

endmodule

bind cascaded_biquad_iir_filter cbq_checker u_cbq_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Cascaded biquad filter testbench
// Streams samples through the four-section filter under several coefficient
// sets and checks every filtered sample and clip flag against a local model.
// ----------------------------------------------------------------------------
// The initial block resets the filter once, then runs a series of phases. Each
// phase after the first writes coefficient registers while the filter is idle,
// queues its samples and waits until every result has come back. The driver
// pops the sample queue into the input stream, and on every accepted input
// transaction it runs the local cascade model and queues the expected result.
// The monitor checks each accepted output transaction against the oldest
// expected result. A watchdog ends the run when nothing moves for too long.
module tb_top;

	import cbq_pkg::*;

	// Longest stretch without any accepted transaction before the run is aborted.
	localparam int STALL_LIMIT     = 4000;
	// Cycles allowed after the last result for stray output transactions.
	localparam int DRAIN_CYCLES    = 40;
	localparam int NUM_RAND_PHASES = 11;
	localparam int PHASE_SAMPLES   = 166;

	typedef struct {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           clear;
	} sample_item_t;

	typedef struct {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           clipped;
	} filtered_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [REG_WIDTH-1:0]       cfg_data = '0;

	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_WIDTH-1:0] s_tdata = '0;  // [15:0] sample_in
	logic                   s_tuser = 1'b0; // [0] clear_history

	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_WIDTH-1:0] m_tdata;  // [15:0] sample_out
	logic                   m_tuser;  // [0] saturated

	// Percentages of cycles in which the sender or the receiver holds back.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int failures = 0;
	int quiet_cycles = 0;

	sample_item_t sample_queue[$];
	filtered_t    filtered_expect[$];

	// Local copy of the coefficient registers and the delay lines.
	logic [REG_WIDTH-1:0]            coef_bank [NUM_REGS];
	logic signed [SAMPLE_WIDTH-1:0]  x_hist [2];
	logic signed [SECTION_WIDTH-1:0] y_hist [NUM_SECTIONS][2];

	cascaded_biquad_iir_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Cascade model
	// ------------------------------------------------------------------------

	// One Q2.14 coefficient of one section. A field that would run past the top
	// of its register reads as zero.
	function automatic longint coef_at(input coef_reg_t kind, input int sec);
		logic signed [COEF_WIDTH-1:0] c;
		if ((sec + 1) * COEF_WIDTH > REG_WIDTH)
			return 0;
		c = coef_bank[kind][sec*COEF_WIDTH +: COEF_WIDTH];
		return c;
	endfunction

	function automatic longint clip_to(input longint v, input int w, inout logic clipped);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clipped = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clipped = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// Runs one sample through all sections and advances the delay lines.
	// Each sum of products is rounded half up to Q9.15 and clipped to 24 bits;
	// the output of the last section is clipped once more to 16 bits.
	function automatic filtered_t run_cascade(input logic signed [SAMPLE_WIDTH-1:0] sample,
	                                          input logic clear);
		filtered_t r;
		longint    cur;
		longint    in1;
		longint    in2;
		longint    p1;
		longint    p2;
		longint    acc;
		logic      clipped;
		clipped = 1'b0;
		if (clear) begin
			x_hist[0] = '0;
			x_hist[1] = '0;
			for (int s = 0; s < NUM_SECTIONS; s++) begin
				y_hist[s][0] = '0;
				y_hist[s][1] = '0;
			end
		end
		cur = sample;
		in1 = x_hist[0];
		in2 = x_hist[1];
		x_hist[1] = x_hist[0];
		x_hist[0] = sample;
		// A section's delayed inputs are the previous section's delayed outputs.
		for (int s = 0; s < NUM_SECTIONS; s++) begin
			p1 = y_hist[s][0];
			p2 = y_hist[s][1];
			acc = coef_at(REG_B0, s) * cur + coef_at(REG_B1, s) * in1
			    + coef_at(REG_B2, s) * in2 - coef_at(REG_A1, s) * p1
			    - coef_at(REG_A2, s) * p2;
			acc = acc + (longint'(1) <<< (COEF_FRAC - 1));
			cur = clip_to(acc >>> COEF_FRAC, SECTION_WIDTH, clipped);
			y_hist[s][1] = y_hist[s][0];
			y_hist[s][0] = cur[SECTION_WIDTH-1:0];
			in1 = p1;
			in2 = p2;
		end
		r.sample = SAMPLE_WIDTH'(clip_to(cur, SAMPLE_WIDTH, clipped));
		r.clipped = clipped;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Driver: feeds queued samples into the input stream.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : sample_driver
		sample_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			// The expected result is worked out when the filter takes the sample.
			if (s_tvalid && s_tready)
				filtered_expect.push_back(run_cascade($signed(s_tdata[SAMPLE_WIDTH-1:0]),
				                                      s_tuser));
			if (!s_tvalid || s_tready) begin
				if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = sample_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= TDATA_WIDTH'(nxt.sample);
					s_tuser <= nxt.clear;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks each output transaction and throttles the output stream.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		filtered_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (filtered_expect.size() == 0) begin
					$error("unexpected result: sample_out %0d, saturated %0d",
					       $signed(m_tdata[SAMPLE_WIDTH-1:0]), m_tuser);
					failures++;
				end else begin
					want = filtered_expect.pop_front();
					if ($signed(m_tdata[SAMPLE_WIDTH-1:0]) !== want.sample) begin
						$error("sample_out mismatch: expected %0d, got %0d",
						       want.sample, $signed(m_tdata[SAMPLE_WIDTH-1:0]));
						failures++;
					end
					if (m_tuser !== want.clipped) begin
						$error("saturated mismatch: expected %0d, got %0d",
						       want.clipped, m_tuser);
						failures++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: any accepted transaction on any channel counts as progress.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// One register write transaction. The local register copy follows the
	// filter's rule that an index past the last register is dropped.
	task automatic write_coef(input logic [CFG_INDEX_WIDTH-1:0] idx,
	                          input logic [REG_WIDTH-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx < NUM_REGS)
			coef_bank[idx] = value;
	endtask

	task automatic write_unused_indexes();
		for (int i = NUM_REGS; i < (1 << CFG_INDEX_WIDTH); i++)
			write_coef(CFG_INDEX_WIDTH'(i), {$urandom, $urandom});
	endtask

	task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] sample,
	                           input logic clear);
		sample_item_t it;
		it.sample = sample;
		it.clear = clear;
		sample_queue.push_back(it);
	endtask

	// Returns once every queued sample has gone in and every result is out.
	// The check runs at the falling edge, when the driver and the monitor have
	// finished their updates of the rising edge.
	task automatic wait_drained();
		do @(negedge clk);
		while (sample_queue.size() != 0 || s_tvalid || filtered_expect.size() != 0);
	endtask

	// Sections that stay stable most of the time: a2 at most 0.75 and a1 kept
	// inside the stability triangle with some margin.
	function automatic logic [REG_WIDTH-1:0] stable_pack(input coef_reg_t kind, input int b_span);
		logic [REG_WIDTH-1:0] pk;
		int a2;
		int lim;
		int v;
		pk = '0;
		for (int s = 0; s < NUM_SECTIONS; s++) begin
			a2 = int'($urandom_range(12288));
			lim = 16384 + a2 - 2048;
			case (kind)
				REG_A1: v = int'($urandom_range(2 * lim)) - lim;
				REG_A2: v = a2;
				default: v = int'($urandom_range(2 * b_span - 1)) - b_span;
			endcase
			pk[s*COEF_WIDTH +: COEF_WIDTH] = COEF_WIDTH'(v);
		end
		return pk;
	endfunction

	function automatic logic [REG_WIDTH-1:0] extreme_pack();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return {NUM_SECTIONS{16'h8000}};
			3: return {NUM_SECTIONS{16'h7fff}};
			4: return {NUM_SECTIONS{16'h4000}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Style 0 and 3 are mostly stable filters, 1 is fully random words with
	// stray writes to unused indexes, 2 picks corner patterns per register.
	task automatic program_phase(input int style);
		logic [REG_WIDTH-1:0] value;
		coef_reg_t kind;
		if (style == 1)
			write_unused_indexes();
		for (int k = 0; k < NUM_REGS; k++) begin
			kind = coef_reg_t'(k);
			case (style)
				0: value = stable_pack(kind, 8192);
				1: value = {$urandom, $urandom};
				2: value = extreme_pack();
				default: value = stable_pack(kind, 16384);
			endcase
			write_coef(kind, value);
		end
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return SAMPLE_WIDTH'(int'($urandom_range(511)) - 256);
			3: return SAMPLE_WIDTH'(int'($urandom_range(2)) - 1);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		for (int k = 0; k < NUM_REGS; k++)
			coef_bank[k] = '0;
		coef_bank[REG_B0] = {NUM_SECTIONS{16'h4000}};
		x_hist[0] = '0;
		x_hist[1] = '0;
		for (int s = 0; s < NUM_SECTIONS; s++) begin
			y_hist[s][0] = '0;
			y_hist[s][1] = '0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part runs with a lazy receiver and a mostly busy sender.
		send_idle_pct = 22;
		recv_idle_pct = 87;

		// Reset coefficients: unity gain in every section, so samples pass as is.
		push_sample(16'sh0000, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh0001, 1'b0);
		push_sample(-16'sh0001, 1'b0);
		push_sample(16'sh5555, 1'b0);
		push_sample(16'shaaaa, 1'b1);
		push_sample(16'sh04d2, 1'b0);
		wait_drained();

		// Gain near two per section: the output clips while sections do not.
		// Writes to indexes past the last register must leave the bank alone.
		write_unused_indexes();
		write_coef(REG_B0, {NUM_SECTIONS{16'h7fff}});
		write_coef(REG_B1, '0);
		write_coef(REG_B2, '0);
		write_coef(REG_A1, '0);
		write_coef(REG_A2, '0);
		push_sample(16'sh7fff, 1'b1);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh0064, 1'b0);
		push_sample(-16'sh0064, 1'b0);
		push_sample(16'sh0000, 1'b0);
		wait_drained();

		// Full-scale feedforward and feedback: the sections clip as well.
		write_coef(REG_B1, {NUM_SECTIONS{16'h7fff}});
		write_coef(REG_B2, {NUM_SECTIONS{16'h8000}});
		write_coef(REG_A1, {NUM_SECTIONS{16'h8000}});
		write_coef(REG_A2, {NUM_SECTIONS{16'h7fff}});
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh0000, 1'b0);
		push_sample(16'sh0000, 1'b0);
		push_sample(16'sh03e8, 1'b1);
		push_sample(16'sh4e20, 1'b0);
		push_sample(-16'sh0001, 1'b0);
		wait_drained();

		// Random part. The idling pattern moves from a slow receiver to a slow
		// sender and then to full speed on both sides.
		for (int p = 0; p < NUM_RAND_PHASES; p++) begin
			if (p < 4) begin
				send_idle_pct = 22;
				recv_idle_pct = 87;
			end else if (p < 8) begin
				send_idle_pct = 87;
				recv_idle_pct = 22;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			program_phase(p % 4);
			for (int i = 0; i < PHASE_SAMPLES; i++)
				push_sample(random_sample(), $urandom_range(24) == 0);
			wait_drained();
		end

		// Leave room for any result the filter should not have produced.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/cbq_pkg.sv
hw/rtl/cascaded_biquad_iir_filter.sv
hw/rtl/cbq_checker.sv
tb/sv/tb_top.sv
